// ----- rtl/sdss_pkg.sv -----
package sdss_pkg;

    // Display size
    localparam int DIGIT_COUNT  = 6;
    localparam int BIT_COUNT    = DIGIT_COUNT * 8;
    localparam int RESULT_COUNT = BIT_COUNT + 1;
    localparam int RIGHT_BASE   = DIGIT_COUNT - 3;

    function automatic longint pow10(input int n);
        longint v;
        v = 1;
        for (int i = 0; i < n; i++) begin
            v = v * 10;
        end
        return v;
    endfunction

    localparam longint FULL_MAX = pow10(DIGIT_COUNT) - 1;
    localparam int FULL_W = $clog2(FULL_MAX + 1);
    // value register must also hold 999
    localparam int VAL_W  = (FULL_W > 10) ? FULL_W : 10;
    localparam logic [31:0] FULL_MAX_32  = 32'(FULL_MAX);
    localparam logic [31:0] SMALL_MAX_32 = 32'd999;

    localparam int POS_W  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int DCNT_W = 3;
    localparam int CNT_W  = $clog2(RESULT_COUNT);

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef logic [7:0] t_byte;
    typedef t_byte [DIGIT_COUNT-1:0] t_pat;

    typedef enum logic [2:0] {
        OP_NUMBER6     = 3'd0,
        OP_LEFT3       = 3'd1,
        OP_RIGHT3      = 3'd2,
        OP_SEG_LEFT    = 3'd3,
        OP_SEG_RIGHT   = 3'd4,
        OP_SEG_ALL     = 3'd5,
        OP_PATTERN_ALL = 3'd6,
        OP_CLEAR       = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIGIT,
        F_PUSH
    } t_front_state;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MSB     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd2;

    typedef struct packed {
        logic invert;
        logic msb_first;
        logic reverse;
    } t_cfg;

    // Decimal digit to segment pattern
    function automatic t_byte seg_of(input logic [3:0] d);
        t_byte s;
        unique case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/sdss_cmd_if.sv -----
interface sdss_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] number_value;
    logic [7:0]  segment_0;
    logic [7:0]  segment_1;
    logic [7:0]  segment_2;
    logic [7:0]  segment_3;
    logic [7:0]  segment_4;
    logic [7:0]  segment_5;

    modport source (
        output valid, opcode, number_value,
               segment_0, segment_1, segment_2, segment_3, segment_4, segment_5,
        input  ready
    );
    modport sink (
        input  valid, opcode, number_value,
               segment_0, segment_1, segment_2, segment_3, segment_4, segment_5,
        output ready
    );
endinterface

// ----- rtl/sdss_res_if.sv -----
interface sdss_res_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_pulse;
    logic last_result;

    modport source (
        output valid, serial_bit, latch_pulse, last_result,
        input  ready
    );
    modport sink (
        input  valid, serial_bit, latch_pulse, last_result,
        output ready
    );
endinterface

// ----- rtl/six_digit_seven_segment_serializer_unit.sv -----
// Path: a taken word is decoded in the front end, one decimal digit at a time for
//   number commands (six for a full number, three otherwise), queued, then serialized.
// Throughput: 49 output words per command (48 bits and the latch), one per
//   cycle while the receiver is ready, set by the bit serializer; a two-entry
//   queue lets the next command be decoded meanwhile. Synchronous active-low reset
//   empties the queue and the pipeline and sets invert, msb-first and reverse order to 1.
module six_digit_seven_segment_serializer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sdss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic                            i_cfg_data,
    sdss_cmd_if.sink                        i_cmd,
    sdss_res_if.source                      o_res
);
    import sdss_pkg::*;

    t_cfg  r_cfg;
    logic  push, pop, full, empty;
    t_pat  push_pat, pop_pat;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{invert: 1'b1, msb_first: 1'b1, reverse: 1'b1};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INVERT:  r_cfg.invert    <= i_cfg_data;
                CFG_MSB:     r_cfg.msb_first <= i_cfg_data;
                CFG_REVERSE: r_cfg.reverse   <= i_cfg_data;
                default:     r_cfg           <= r_cfg;
            endcase
        end
    end

    sdss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_full     (full),
        .o_push     (push),
        .o_push_pat (push_pat)
    );

    sdss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_pat),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (pop_pat)
    );

    sdss_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_data  (pop_pat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ----- rtl/sdss_front.sv -----
module sdss_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sdss_cmd_if.sink        i_cmd,
    input  logic            i_full,
    output logic            o_push,
    output sdss_pkg::t_pat  o_push_pat
);
    import sdss_pkg::*;

    localparam logic signed [4:0] DC_S = 5'(DIGIT_COUNT);

    t_front_state       r_state, n_state;
    t_opcode            r_op, n_op;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;
    t_pat               r_pat, n_pat;

    t_opcode            op_in;
    logic               accept;
    logic [VAL_W-1:0]   sat_val;
    t_pat               raw_pat;
    t_byte              seg_in [6];
    logic [63:0]        prod;
    logic [VAL_W-1:0]   quot;
    logic [3:0]         rem;
    logic signed [4:0]  pos;
    logic               pos_ok;
    logic               last_digit;

    assign op_in  = t_opcode'(i_cmd.opcode);
    assign accept = i_cmd.valid && i_cmd.ready;
    assign seg_in = '{i_cmd.segment_0, i_cmd.segment_1, i_cmd.segment_2,
                      i_cmd.segment_3, i_cmd.segment_4, i_cmd.segment_5};

    // Ready when idle, or when the finished word moves into the queue
    assign i_cmd.ready = (r_state == F_IDLE) || ((r_state == F_PUSH) && !i_full);

    // Saturate the number for the selected width
    always_comb begin
        if (op_in == OP_NUMBER6) begin
            sat_val = (i_cmd.number_value > FULL_MAX_32) ?
                      VAL_W'(FULL_MAX_32) : VAL_W'(i_cmd.number_value);
        end else begin
            sat_val = (i_cmd.number_value > SMALL_MAX_32) ?
                      VAL_W'(SMALL_MAX_32) : VAL_W'(i_cmd.number_value);
        end
    end

    // Raw pattern commands are placed combinationally, without digit steps
    always_comb begin
        for (int p = 0; p < DIGIT_COUNT; p++) begin
            raw_pat[p] = 8'h00;
            case (op_in)
                OP_SEG_LEFT: begin
                    for (int j = 0; j < 3; j++) begin
                        if (p == j) raw_pat[p] = seg_in[j];
                    end
                end
                OP_SEG_RIGHT: begin
                    for (int j = 0; j < 3; j++) begin
                        if (p == RIGHT_BASE + j) raw_pat[p] = seg_in[j];
                    end
                end
                OP_SEG_ALL: begin
                    for (int j = 0; j < 6; j++) begin
                        if (p == j) raw_pat[p] = seg_in[j];
                    end
                end
                OP_PATTERN_ALL: raw_pat[p] = seg_in[0];
                default: raw_pat[p] = 8'h00;
            endcase
        end
    end

    // One decimal digit per cycle, least significant first
    assign prod = {32'd0, {(32 - VAL_W){1'b0}}, r_val} * {32'd0, RECIP_10};
    assign quot = VAL_W'(prod[63:RECIP_SHIFT]);
    assign rem  = 4'(r_val) - 4'({quot, 3'b000}) - 4'({quot, 1'b0});

    assign pos = ((r_op == OP_LEFT3) ? 5'sd2 : (DC_S - 5'sd1))
                 - $signed({{(5 - DCNT_W){1'b0}}, r_cnt});
    assign pos_ok = (pos >= 5'sd0) && (pos < DC_S);
    assign last_digit = (r_op == OP_NUMBER6) ? (r_cnt == DCNT_W'(DIGIT_COUNT - 1))
                                             : (r_cnt == DCNT_W'(2));

    assign o_push_pat = r_pat;

    // Next state and outputs
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_pat       = r_pat;
        o_push      = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                n_state = F_IDLE;
            end
            F_DIGIT: begin
                if (pos_ok) n_pat[pos[POS_W-1:0]] = seg_of(rem);
                n_val = quot;
                n_cnt = r_cnt + DCNT_W'(1);
                if (last_digit) n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push      = 1'b1;
                    n_state     = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
        // New word loads over whatever finished above
        if (accept) begin
            n_op  = op_in;
            n_val = sat_val;
            n_cnt = '0;
            if (op_in == OP_NUMBER6 || op_in == OP_LEFT3 || op_in == OP_RIGHT3) begin
                n_pat   = '0;
                n_state = F_DIGIT;
            end else begin
                n_pat   = raw_pat;
                n_state = F_PUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_cnt <= n_cnt;
        r_pat <= n_pat;
    end

endmodule

// ----- rtl/sdss_queue.sv -----
module sdss_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sdss_pkg::t_pat  i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output sdss_pkg::t_pat  o_data
);
    import sdss_pkg::*;

    t_pat        r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ----- rtl/sdss_back.sv -----
module sdss_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdss_pkg::t_cfg  i_cfg,
    input  logic            i_empty,
    input  sdss_pkg::t_pat  i_data,
    output logic            o_pop,
    sdss_res_if.source      o_res
);
    import sdss_pkg::*;

    logic              r_busy;
    t_pat              r_pat;
    logic [CNT_W-1:0]  r_cnt;

    logic              last;
    logic              adv;
    logic [POS_W-1:0]  k;
    logic [POS_W-1:0]  pos;
    t_byte             cur;
    logic [2:0]        bi;
    logic              bit_val;

    assign last  = (r_cnt == CNT_W'(BIT_COUNT));
    assign adv   = r_busy && o_res.ready;
    assign o_pop = !i_empty && (!r_busy || (adv && last));

    // Pick byte and bit for the current result
    assign k   = POS_W'(r_cnt[CNT_W-1:3]);
    assign pos = i_cfg.reverse ? (POS_W'(DIGIT_COUNT - 1) - k) : k;
    assign cur = r_pat[pos] ^ {8{i_cfg.invert}};
    assign bi  = r_cnt[2:0];
    assign bit_val = i_cfg.msb_first ? cur[3'd7 - bi] : cur[bi];

    assign o_res.valid       = r_busy;
    assign o_res.serial_bit  = last ? 1'b0 : bit_val;
    assign o_res.latch_pulse = last;
    assign o_res.last_result = last;

    // Bit counter, reloads straight from the queue after the latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (adv && last) begin
            r_busy <= 1'b0;
        end else if (adv) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_pat <= i_data;
    end

endmodule

// ----- rtl/sdss_checker.sv -----
module sdss_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic i_ready,
    input logic i_serial,
    input logic i_latch,
    input logic i_last
);
    import sdss_pkg::*;

    logic [CNT_W-1:0] r_cnt;

    // Output words seen since the last latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_valid && i_ready) begin
            r_cnt <= i_latch ? '0 : (r_cnt + CNT_W'(1));
        end
    end

    a_latch_after_all_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_latch |-> r_cnt == CNT_W'(BIT_COUNT))
        else $error("latch before all bits were sent");

    a_latch_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_cnt == CNT_W'(BIT_COUNT) |-> i_latch)
        else $error("missing latch after all bits");

    a_latch_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_latch |-> !i_serial && i_last)
        else $error("latch word malformed");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_serial, i_latch, i_last}))
        else $error("output word changed while stalled");

endmodule

bind six_digit_seven_segment_serializer_unit sdss_checker u_sdss_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_serial (o_res.serial_bit),
    .i_latch  (o_res.latch_pulse),
    .i_last   (o_res.last_result)
);

// ----- tb/tb_six_digit_seven_segment_serializer_unit.sv -----
module tb_six_digit_seven_segment_serializer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sdss_pkg::*;

    localparam int HOLD_CYCLES    = 300;   // long receiver stall, applied once
    localparam int HOLD_AT_WORD   = 2500;  // result word count that triggers it
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RAND_PHASES    = 8;
    localparam int ITEMS_PER_PH   = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // digit 0..9 to segment byte
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
    };

    typedef struct {
        t_opcode     op;
        logic [31:0] number;
        logic [7:0]  seg [6];
    } t_display_cmd;

    typedef struct {
        logic serial_bit;
        logic latch_pulse;
        logic last_result;
    } t_shift_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic cfg_data;

    sdss_cmd_if cmd_if();
    sdss_res_if res_if();

    six_digit_seven_segment_serializer_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    always #6 i_clk = ~i_clk;

    // local copy of the display settings
    logic inv_cfg, msb_cfg, rev_cfg;

    t_display_cmd pending_cmds [$];
    t_display_cmd cmd_cur;
    t_shift_word  shift_words_q [$];

    int  err_cnt     = 0;
    int  cmds_taken  = 0;
    int  words_seen  = 0;
    int  cfg_writes  = 0;
    int  idle_cycles = 0;
    bit  tx_idle_on  = 1'b0;
    bit  rx_idle_on  = 1'b0;
    bit  hold_done   = 1'b0;
    int  tx_gap      = 0;
    int  rx_stall    = 0;
    int  hold_left   = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_display_cmd mk_cmd(input t_opcode op, input logic [31:0] num,
                                            input logic [47:0] segs);
        t_display_cmd c;
        c.op = op;
        c.number = num;
        for (int i = 0; i < 6; i++) c.seg[i] = segs[8*i +: 8];
        return c;
    endfunction

    function automatic t_display_cmd random_cmd();
        t_display_cmd c;
        int r;
        c.op = t_opcode'($urandom_range(0, 7));
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2: c.number = $urandom;
            3:       c.number = $urandom_range(0, 999);
            4:       c.number = $urandom_range(0, 999999);
            5: begin
                case ($urandom_range(0, 5))
                    0: c.number = 32'd999;
                    1: c.number = 32'd1000;
                    2: c.number = 32'd999999;
                    3: c.number = 32'd1000000;
                    4: c.number = 32'd0;
                    default: c.number = 32'hFFFF_FFFF;
                endcase
            end
            default: c.number = $urandom_range(0, 2000000);
        endcase
        for (int i = 0; i < 6; i++) c.seg[i] = $urandom_range(0, 255);
        return c;
    endfunction

    // Build the six position bytes, then push 48 bit words and the latch word
    function automatic void predict_shift_stream(input t_display_cmd c);
        logic [7:0] pat [DIGIT_COUNT];
        longint unsigned lim, v;
        int base, pos;
        logic [7:0] b;
        t_shift_word w;
        for (int i = 0; i < DIGIT_COUNT; i++) pat[i] = 8'h00;
        base = (c.op == OP_RIGHT3 || c.op == OP_SEG_RIGHT) ? DIGIT_COUNT - 3 : 0;
        case (c.op)
            OP_NUMBER6: begin
                lim = 1;
                for (int i = 0; i < DIGIT_COUNT; i++) lim = lim * 10;
                v = c.number;
                if (v > lim - 1) v = lim - 1;
                for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
                    pat[i] = DIGIT_SEGS[v % 10];
                    v = v / 10;
                end
            end
            OP_LEFT3, OP_RIGHT3: begin
                v = (c.number > 32'd999) ? 999 : c.number;
                for (int j = 2; j >= 0; j--) begin
                    if (base + j >= 0 && base + j < DIGIT_COUNT) pat[base + j] = DIGIT_SEGS[v % 10];
                    v = v / 10;
                end
            end
            OP_SEG_LEFT, OP_SEG_RIGHT: begin
                for (int j = 0; j < 3; j++)
                    if (base + j >= 0 && base + j < DIGIT_COUNT) pat[base + j] = c.seg[j];
            end
            OP_SEG_ALL: begin
                for (int i = 0; i < DIGIT_COUNT && i < 6; i++) pat[i] = c.seg[i];
            end
            OP_PATTERN_ALL: begin
                for (int i = 0; i < DIGIT_COUNT; i++) pat[i] = c.seg[0];
            end
            default: ;
        endcase
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            pos = rev_cfg ? DIGIT_COUNT - 1 - k : k;
            b = inv_cfg ? ~pat[pos] : pat[pos];
            for (int i = 0; i < 8; i++) begin
                w.serial_bit  = msb_cfg ? b[7 - i] : b[i];
                w.latch_pulse = 1'b0;
                w.last_result = 1'b0;
                shift_words_q.push_back(w);
            end
        end
        w.serial_bit  = 1'b0;
        w.latch_pulse = 1'b1;
        w.last_result = 1'b1;
        shift_words_q.push_back(w);
    endfunction

    function automatic void check_bit(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            $display("%0t: word %0d %s expected %b actual %b", $time, words_seen, name,
                     exp_v, act_v);
            err_cnt++;
        end
    endfunction

    // Command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                predict_shift_stream(cmd_cur);
                cmds_taken++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    cmd_cur = pending_cmds.pop_front();
                    cmd_if.valid        <= 1'b1;
                    cmd_if.opcode       <= cmd_cur.op;
                    cmd_if.number_value <= cmd_cur.number;
                    cmd_if.segment_0    <= cmd_cur.seg[0];
                    cmd_if.segment_1    <= cmd_cur.seg[1];
                    cmd_if.segment_2    <= cmd_cur.seg[2];
                    cmd_if.segment_3    <= cmd_cur.seg[3];
                    cmd_if.segment_4    <= cmd_cur.seg[4];
                    cmd_if.segment_5    <= cmd_cur.seg[5];
                    if (tx_idle_on) tx_gap = pick_gap();
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_shift_word exp_w;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (shift_words_q.size() == 0) begin
                    $display("%0t: word %0d unexpected, expected none actual bit=%b latch=%b",
                             $time, words_seen, res_if.serial_bit, res_if.latch_pulse);
                    err_cnt++;
                end else begin
                    exp_w = shift_words_q.pop_front();
                    check_bit("serial_bit", exp_w.serial_bit, res_if.serial_bit);
                    check_bit("latch_pulse", exp_w.latch_pulse, res_if.latch_pulse);
                    check_bit("last_result", exp_w.last_result, res_if.last_result);
                end
                words_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (!hold_done && words_seen >= HOLD_AT_WORD) begin
                // stall long enough to back the block up into its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                res_if.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                rx_stall = pick_gap();
                res_if.ready <= (rx_stall == 0);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding", $time,
                     WATCHDOG_LIMIT, shift_words_q.size());
            $display("six_digit_seven_segment_serializer_unit: mismatch");
            $finish;
        end
    end

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_INVERT:  inv_cfg = data;
            CFG_MSB:     msb_cfg = data;
            CFG_REVERSE: rev_cfg = data;
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // sample at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || cmd_if.valid || shift_words_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: directed commands at reset settings, then random phases
    initial begin
        logic [2:0] sel;
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = OP_CLEAR;
        cmd_if.number_value = '0;
        cmd_if.segment_0    = '0;
        cmd_if.segment_1    = '0;
        cmd_if.segment_2    = '0;
        cmd_if.segment_3    = '0;
        cmd_if.segment_4    = '0;
        cmd_if.segment_5    = '0;
        res_if.ready        = 1'b0;
        inv_cfg = 1'b1;
        msb_cfg = 1'b1;
        rev_cfg = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // number saturation, leading zeros, raw patterns, blanks, clear
        pending_cmds.push_back(mk_cmd(OP_NUMBER6, 32'd0, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_NUMBER6, 32'd999999, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_NUMBER6, 32'd1000000, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_NUMBER6, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_NUMBER6, 32'd123456, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_NUMBER6, 32'd7890, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_LEFT3, 32'd0, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_LEFT3, 32'd999, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_LEFT3, 32'd1000, 48'hFFFF_FFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_LEFT3, 32'd42, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_RIGHT3, 32'd7, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_RIGHT3, 32'd999, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_RIGHT3, 32'hFFFF_FFFF, 48'h0));
        pending_cmds.push_back(mk_cmd(OP_SEG_LEFT, 32'hFFFF_FFFF, 48'h5A5A_5AA5_FF00));
        pending_cmds.push_back(mk_cmd(OP_SEG_RIGHT, 32'd12345, 48'hA5A5_A55A_00FF));
        pending_cmds.push_back(mk_cmd(OP_SEG_ALL, 32'd0, 48'h2010_0804_0201));
        pending_cmds.push_back(mk_cmd(OP_SEG_ALL, 32'd0, 48'hFFFF_FFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_SEG_ALL, 32'd0, 48'h0000_0000_0000));
        pending_cmds.push_back(mk_cmd(OP_PATTERN_ALL, 32'd999, 48'h1234_5678_9A80));
        pending_cmds.push_back(mk_cmd(OP_PATTERN_ALL, 32'd0, 48'h0000_0000_00FF));
        pending_cmds.push_back(mk_cmd(OP_CLEAR, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_CLEAR, 32'd0, 48'h0));
        wait_drained();

        // one phase per setting combination, idling varied across phases
        for (int p = 1; p <= RAND_PHASES; p++) begin
            sel = 3'(p - 1);
            write_cfg(CFG_UNUSED, 1'($urandom_range(0, 1)));
            write_cfg(CFG_INVERT, sel[0]);
            write_cfg(CFG_MSB, sel[1]);
            write_cfg(CFG_REVERSE, sel[2]);
            tx_idle_on = (p % 3) != 0;
            rx_idle_on = (p % 4) != 0;
            for (int i = 0; i < ITEMS_PER_PH; i++) pending_cmds.push_back(random_cmd());
            wait_drained();
        end

        $display("covered %0d commands, %0d result words, %0d setting writes",
                 cmds_taken, words_seen, cfg_writes);
        $display("all opcodes, saturation edges and 8 invert/bit-order/digit-order settings");
        if (err_cnt == 0 && shift_words_q.size() == 0) begin
            $display("six_digit_seven_segment_serializer_unit: match");
        end else begin
            $display("six_digit_seven_segment_serializer_unit: mismatch");
        end
        $finish;
    end

endmodule
